// ===== hw/rtl/rlfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB linear fade engine package
// Item kinds, colour constants and the channel clamp that the engine uses.
// ----------------------------------------------------------------------------
package rlfe_pkg;

   typedef logic [7:0]  colour_type;
   typedef logic [31:0] accum_type;
   typedef logic [15:0] step_type;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_MANUAL = 2'd2;

   localparam int TICK_MS_RESET = 30;
   localparam int FULL_PERCENT  = 100;
   localparam int CHAN_MAX      = 255;
   localparam int FRAC_BITS     = 8;

   // Multiplying by this and shifting right by 19 divides by 100 exactly up to 25500.
   localparam int PCT_RECIP     = 5243;

   localparam logic [0:0] CSR_TICK_MS = 1'b0;

   function automatic colour_type clamp_channel(input accum_type acc);
      colour_type res;
      if (acc[31]) begin
         res = '0;
      end else if (|acc[30:16]) begin
         res = colour_type'(CHAN_MAX);
      end else begin
         res = acc[15:8];
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/rgb_linear_fade_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB linear fade engine
// A tick item's result is registered and shown in the cycle after acceptance; the
// engine takes the next item in the following cycle if no held result stalls it.
// A jump start or an unused kind is handled in the idle state. A linear start runs
// six divisions on one shared serial divider, each a multiply, a load, a 32-bit
// quotient formed bit by bit and a write back. A manual item scales each channel by
// a reciprocal multiply in the multiply, load and write-back states. Synchronous
// reset zeroes the colour accumulators and steps and sets the tick period to 30 ms.
// ----------------------------------------------------------------------------
module rgb_linear_fade_engine_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_kind,
   input  rlfe_pkg::colour_type    req_from_red,
   input  rlfe_pkg::colour_type    req_from_green,
   input  rlfe_pkg::colour_type    req_from_blue,
   input  rlfe_pkg::colour_type    req_to_red,
   input  rlfe_pkg::colour_type    req_to_green,
   input  rlfe_pkg::colour_type    req_to_blue,
   input  logic [15:0]             req_elapsed_time,
   input  logic [15:0]             req_fade_length,
   input  logic                    req_linear_mode,
   input  logic [6:0]              req_brightness,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rlfe_pkg::colour_type    rsp_strip_first,
   output rlfe_pkg::colour_type    rsp_strip_second,
   output rlfe_pkg::colour_type    rsp_strip_third,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import rlfe_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_WB   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        manual_ff, manual_in;
   logic [1:0]  chan_ff, chan_in;
   logic        phase_ff, phase_in;
   colour_type  from_ff [3];
   colour_type  from_in [3];
   colour_type  to_ff [3];
   colour_type  to_in [3];
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] dur_ff, dur_in;
   logic [6:0]  bright_ff, bright_in;
   logic [9:0]  tick_ms_ff, tick_ms_in;
   logic        neg_ff, neg_in;
   logic [23:0] prod_ff, prod_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   accum_type   accum_ff [3];
   accum_type   accum_in [3];
   step_type    step_ff [3];
   step_type    step_in [3];
   logic        rsp_valid_ff, rsp_valid_in;
   colour_type  first_ff, first_in;
   colour_type  second_ff, second_in;
   colour_type  third_ff, third_in;

   logic        req_accept;
   logic        csr_write;
   colour_type  cur_from;
   colour_type  cur_to;
   logic        cur_neg;
   colour_type  abs_diff;
   colour_type  mul_a;
   logic [15:0] mul_b;
   logic [15:0] divisor;
   logic [16:0] shifted;
   logic        div_ge;
   logic [31:0] signed_quo;
   step_type    sat_step;
   logic        last_job;
   logic [26:0] pct_prod;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_strip_first  = first_ff;
   assign rsp_strip_second = second_ff;
   assign rsp_strip_third  = third_ff;

   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_TICK_MS);
   assign csr_prdata  = (csr_paddr[2] == CSR_TICK_MS) ? {22'b0, tick_ms_ff} : 32'b0;
   assign tick_ms_in  = csr_write ? csr_pwdata[9:0] : tick_ms_ff;

   assign cur_from = from_ff[chan_ff];
   assign cur_to   = to_ff[chan_ff];
   assign cur_neg  = cur_to < cur_from;
   assign abs_diff = cur_neg ? (cur_from - cur_to) : (cur_to - cur_from);
   assign mul_a    = manual_ff ? cur_to : abs_diff;
   assign mul_b    = manual_ff ? {9'b0, bright_ff} : (phase_ff ? {6'b0, tick_ms_ff} : elapsed_ff);
   assign divisor  = dur_ff;
   assign shifted  = {rem_ff, quo_ff[31]};
   assign div_ge   = shifted >= {1'b0, divisor};
   assign signed_quo = neg_ff ? (32'd0 - quo_ff) : quo_ff;
   assign last_job = (chan_ff == 2'd2) && (manual_ff || phase_ff);
   assign pct_prod = 27'(prod_ff[14:0]) * 27'(PCT_RECIP);

   always_comb begin
      if (neg_ff) begin
         sat_step = (quo_ff > 32'd32768) ? 16'h8000 : (16'd0 - quo_ff[15:0]);
      end else begin
         sat_step = (quo_ff > 32'd32767) ? 16'h7FFF : quo_ff[15:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      manual_in    = manual_ff;
      chan_in      = chan_ff;
      phase_in     = phase_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      elapsed_in   = elapsed_ff;
      dur_in       = dur_ff;
      bright_in    = bright_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      accum_in     = accum_ff;
      step_in      = step_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      third_in     = third_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_kind)
                  KIND_TICK: begin
                     first_in     = clamp_channel(accum_ff[1]);
                     second_in    = clamp_channel(accum_ff[0]);
                     third_in     = clamp_channel(accum_ff[2]);
                     rsp_valid_in = 1'b1;
                     for (int i = 0; i < 3; i++) begin
                        accum_in[i] = accum_ff[i] + {{16{step_ff[i][15]}}, step_ff[i]};
                     end
                  end
                  KIND_START: begin
                     from_in[0] = req_from_red;
                     from_in[1] = req_from_green;
                     from_in[2] = req_from_blue;
                     to_in[0]   = req_to_red;
                     to_in[1]   = req_to_green;
                     to_in[2]   = req_to_blue;
                     elapsed_in = req_elapsed_time;
                     dur_in     = req_fade_length;
                     manual_in  = 1'b0;
                     chan_in    = 2'd0;
                     phase_in   = 1'b0;
                     if (req_linear_mode && (req_fade_length != 16'd0)) begin
                        state_in = ST_MUL;
                     end else begin
                        accum_in[0] = {16'b0, req_to_red, 8'b0};
                        accum_in[1] = {16'b0, req_to_green, 8'b0};
                        accum_in[2] = {16'b0, req_to_blue, 8'b0};
                        for (int i = 0; i < 3; i++) begin
                           step_in[i] = '0;
                        end
                     end
                  end
                  KIND_MANUAL: begin
                     to_in[0]  = req_to_red;
                     to_in[1]  = req_to_green;
                     to_in[2]  = req_to_blue;
                     bright_in = (req_brightness > 7'(FULL_PERCENT)) ?
                                 7'(FULL_PERCENT) : req_brightness;
                     manual_in = 1'b1;
                     chan_in   = 2'd0;
                     phase_in  = 1'b0;
                     state_in  = ST_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = {16'b0, mul_a} * {8'b0, mul_b};
            neg_in   = !manual_ff && cur_neg;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rem_in = '0;
            cnt_in = '0;
            if (manual_ff) begin
               quo_in   = {24'b0, pct_prod[26:19]};
               state_in = ST_WB;
            end else if (phase_ff) begin
               quo_in   = {6'b0, prod_ff[17:0], 8'b0} + {17'b0, dur_ff[15:1]};
               state_in = ST_DIV;
            end else begin
               quo_in   = {prod_ff, 8'b0};
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? 16'(shifted - {1'b0, divisor}) : shifted[15:0];
            quo_in = {quo_ff[30:0], div_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (manual_ff) begin
               accum_in[chan_ff] = {16'b0, quo_ff[7:0], 8'b0};
               step_in[chan_ff]  = '0;
            end else if (phase_ff) begin
               step_in[chan_ff]  = sat_step;
            end else begin
               accum_in[chan_ff] = signed_quo + {16'b0, cur_from, 8'b0};
            end
            if (last_job) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MUL;
               if (manual_ff || phase_ff) begin
                  chan_in  = chan_ff + 2'd1;
                  phase_in = 1'b0;
               end else begin
                  phase_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ms_ff   <= 10'(TICK_MS_RESET);
         for (int i = 0; i < 3; i++) begin
            accum_ff[i] <= '0;
            step_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ms_ff   <= tick_ms_in;
         accum_ff     <= accum_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      manual_ff  <= manual_in;
      chan_ff    <= chan_in;
      phase_ff   <= phase_in;
      from_ff    <= from_in;
      to_ff      <= to_in;
      elapsed_ff <= elapsed_in;
      dur_ff     <= dur_in;
      bright_ff  <= bright_in;
      neg_ff     <= neg_in;
      prod_ff    <= prod_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      third_ff   <= third_in;
   end

   a_linear_start_runs: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_START && req_linear_mode && req_fade_length != 16'd0)
      |=> state_ff == ST_MUL)
      else $error("A linear segment start did not enter the divider sequence.");

   a_result_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept && req_kind == KIND_TICK))
      else $error("A result item appeared without an accepted tick item.");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < divisor)
      else $error("The divider remainder reached the divisor.");

   a_jump_clears_steps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_START && !(req_linear_mode && req_fade_length != 16'd0))
      |=> (step_ff[0] == '0 && step_ff[1] == '0 && step_ff[2] == '0))
      else $error("A jump start left a nonzero step.");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB linear fade engine testbench
// Sends tick, segment-start and manual items over the request channel. An
// independent fixed-point model of the colour accumulators and per-tick steps
// predicts the strip bytes of every tick, and each result is compared in
// order. The tick period register is swept through its extremes between
// phases, and both channels are throttled at random.
// ----------------------------------------------------------------------------
module testbench;
   import rlfe_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      colour_type  from_red;
      colour_type  from_green;
      colour_type  from_blue;
      colour_type  to_red;
      colour_type  to_green;
      colour_type  to_blue;
      logic [15:0] elapsed_time;
      logic [15:0] fade_length;
      logic        linear_mode;
      logic [6:0]  brightness;
   } fade_item_type;

   typedef struct {
      colour_type strip_first;
      colour_type strip_second;
      colour_type strip_third;
   } strip_bytes_type;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   colour_type  req_from_red;
   colour_type  req_from_green;
   colour_type  req_from_blue;
   colour_type  req_to_red;
   colour_type  req_to_green;
   colour_type  req_to_blue;
   logic [15:0] req_elapsed_time;
   logic [15:0] req_fade_length;
   logic        req_linear_mode;
   logic [6:0]  req_brightness;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   colour_type  rsp_strip_first;
   colour_type  rsp_strip_second;
   colour_type  rsp_strip_third;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   accum_type       colour_level [3];
   step_type        colour_rate [3];
   logic [9:0]      tick_period;
   strip_bytes_type pending_strips [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int failures = 0;
   int items_sent = 0;
   int strips_checked = 0;
   int period_settings = 0;
   int idle_cycles = 0;

   rgb_linear_fade_engine_unit dut (.*);

   always #1 clock = ~clock;

   function automatic colour_type strip_byte(input accum_type acc);
      if (acc[31]) return 8'd0;
      if (acc[31:8] > 24'd255) return 8'd255;
      return acc[15:8];
   endfunction

   function automatic step_type per_tick_step(input longint span, input longint dur);
      longint mag;
      longint q;
      mag = (span < 0) ? -span : span;
      q = (mag + dur / 2) / dur;
      if (span < 0) begin
         if (q > 32768) q = 32768;
         return step_type'(-q);
      end
      if (q > 32767) q = 32767;
      return step_type'(q);
   endfunction

   function automatic bit advance_fade_model(input fade_item_type it,
         output strip_bytes_type strip);
      colour_type from_c [3];
      colour_type to_c [3];
      longint f;
      longint t;
      longint diff;
      longint dur;
      longint level;
      int pct;
      bit produced;
      from_c = '{it.from_red, it.from_green, it.from_blue};
      to_c = '{it.to_red, it.to_green, it.to_blue};
      dur = it.fade_length;
      pct = (it.brightness > FULL_PERCENT) ? FULL_PERCENT : int'(it.brightness);
      produced = 1'b0;
      strip = '{default: '0};
      case (it.kind)
         KIND_TICK: begin
            strip.strip_first = strip_byte(colour_level[1]);
            strip.strip_second = strip_byte(colour_level[0]);
            strip.strip_third = strip_byte(colour_level[2]);
            for (int c = 0; c < 3; c++) begin
               colour_level[c] += {{16{colour_rate[c][15]}}, colour_rate[c]};
            end
            produced = 1'b1;
         end
         KIND_START: begin
            for (int c = 0; c < 3; c++) begin
               if (it.linear_mode && dur != 0) begin
                  f = from_c[c];
                  t = to_c[c];
                  diff = t - f;
                  level = (diff * 256 * longint'(it.elapsed_time)) / dur + f * 256;
                  colour_level[c] = accum_type'(level);
                  colour_rate[c] = per_tick_step(diff * 256 * longint'(tick_period), dur);
               end else begin
                  colour_level[c] = accum_type'(to_c[c]) << FRAC_BITS;
                  colour_rate[c] = '0;
               end
            end
         end
         KIND_MANUAL: begin
            for (int c = 0; c < 3; c++) begin
               colour_level[c] = accum_type'((int'(to_c[c]) * pct) / FULL_PERCENT) << FRAC_BITS;
               colour_rate[c] = '0;
            end
         end
         default: begin
         end
      endcase
      return produced;
   endfunction

   function automatic fade_item_type make_item(input logic [1:0] kind,
         input colour_type fr, input colour_type fg, input colour_type fb,
         input colour_type tr, input colour_type tg, input colour_type tb,
         input logic [15:0] elapsed, input logic [15:0] dur,
         input logic lin, input logic [6:0] bright);
      fade_item_type it;
      it.kind = kind;
      it.from_red = fr;
      it.from_green = fg;
      it.from_blue = fb;
      it.to_red = tr;
      it.to_green = tg;
      it.to_blue = tb;
      it.elapsed_time = elapsed;
      it.fade_length = dur;
      it.linear_mode = lin;
      it.brightness = bright;
      return it;
   endfunction

   function automatic fade_item_type random_item();
      return make_item(2'($urandom_range(0, 3)),
         8'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), 8'($urandom), 8'($urandom),
         16'($urandom), 16'($urandom), 1'($urandom), 7'($urandom));
   endfunction

   task automatic send_item(input fade_item_type it);
      strip_bytes_type strip;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= it.kind;
      req_from_red <= it.from_red;
      req_from_green <= it.from_green;
      req_from_blue <= it.from_blue;
      req_to_red <= it.to_red;
      req_to_green <= it.to_green;
      req_to_blue <= it.to_blue;
      req_elapsed_time <= it.elapsed_time;
      req_fade_length <= it.fade_length;
      req_linear_mode <= it.linear_mode;
      req_brightness <= it.brightness;
      do @(posedge clock); while (!req_ready);
      if (advance_fade_model(it, strip)) pending_strips.push_back(strip);
      items_sent++;
   endtask

   task automatic send_tick();
      fade_item_type it;
      it = random_item();
      it.kind = KIND_TICK;
      send_item(it);
   endtask

   task automatic wait_for_strips();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_strips.size() != 0) @(posedge clock);
   endtask

   task automatic drain_engine();
      wait_for_strips();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tick_period(input int period);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * CSR_TICK_MS);
      csr_pwdata <= 32'(period);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tick_period = 10'(period);
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[9:0] !== tick_period) begin
         $error("tick_ms readback: expected %0d, got %0d", tick_period, csr_prdata[9:0]);
         failures++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      period_settings++;
   endtask

   task automatic test_reset_state();
      send_tick();
      send_tick();
   endtask

   task automatic test_jump_and_manual();
      send_item(make_item(KIND_START, 8'h12, 8'h34, 8'h56, 8'hFF, 8'h00, 8'h80,
         16'd100, 16'd1000, 1'b0, 7'd0));
      send_tick();
      send_item(make_item(KIND_START, 8'h00, 8'h00, 8'h00, 8'hAA, 8'h55, 8'hFF,
         16'hFFFF, 16'd0, 1'b1, 7'd0));
      send_tick();
      send_item(make_item(KIND_MANUAL, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
         16'd0, 16'd0, 1'b0, 7'd100));
      send_tick();
      send_item(make_item(KIND_MANUAL, 8'hFF, 8'hFF, 8'hFF, 8'd200, 8'd100, 8'd7,
         16'hFFFF, 16'hFFFF, 1'b1, 7'd127));
      send_tick();
      send_item(make_item(KIND_MANUAL, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
         16'd0, 16'd0, 1'b0, 7'd0));
      send_tick();
      send_item(make_item(KIND_MANUAL, 8'h00, 8'h00, 8'h00, 8'd201, 8'd3, 8'd99,
         16'd0, 16'd0, 1'b0, 7'd50));
      send_item(make_item(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
         16'hFFFF, 16'hFFFF, 1'b1, 7'h7F));
      send_tick();
   endtask

   task automatic test_linear_extremes();
      send_item(make_item(KIND_START, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
         16'd0, 16'd1, 1'b1, 7'd0));
      send_tick();
      send_tick();
      send_item(make_item(KIND_START, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0,
         16'd0, 16'd1, 1'b1, 7'd0));
      send_tick();
      send_tick();
      send_item(make_item(KIND_START, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
         16'hFFFF, 16'd1, 1'b1, 7'd0));
      send_tick();
      send_item(make_item(KIND_START, 8'd0, 8'd128, 8'd255, 8'd255, 8'd127, 8'd0,
         16'd32767, 16'hFFFF, 1'b1, 7'd0));
      send_tick();
      send_item(make_item(KIND_START, 8'd10, 8'd11, 8'd12, 8'd11, 8'd10, 8'd12,
         16'd0, 16'd15360, 1'b1, 7'd0));
      send_tick();
      send_tick();
   endtask

   task automatic test_fade_sequences(input int item_count, input int period,
         input int idle_pct, input int stall_pct);
      fade_item_type it;
      int sent_here;
      drain_engine();
      write_tick_period(period);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      sent_here = 0;
      while (sent_here < item_count) begin
         it = random_item();
         case ($urandom_range(0, 9))
            0: begin
            end
            1: it.kind = KIND_MANUAL;
            2: it.kind = KIND_START;
            default: begin
               it.kind = KIND_START;
               it.linear_mode = 1'b1;
               it.fade_length = 16'($urandom_range(1, 3000));
               it.elapsed_time = 16'($urandom_range(0, int'(it.fade_length) + 200));
            end
         endcase
         send_item(it);
         sent_here++;
         repeat ($urandom_range(1, 12)) begin
            send_tick();
            sent_here++;
         end
         if ($urandom_range(0, 19) == 0) wait_for_strips();
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic check_byte(input string name, input colour_type want, input colour_type got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      strip_bytes_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_strips.size() == 0) begin
            $error("strip result with no item waiting: %0d %0d %0d",
               rsp_strip_first, rsp_strip_second, rsp_strip_third);
            failures++;
         end else begin
            want = pending_strips.pop_front();
            check_byte("strip_first", want.strip_first, rsp_strip_first);
            check_byte("strip_second", want.strip_second, rsp_strip_second);
            check_byte("strip_third", want.strip_third, rsp_strip_third);
            strips_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_TICK;
      req_from_red = '0;
      req_from_green = '0;
      req_from_blue = '0;
      req_to_red = '0;
      req_to_green = '0;
      req_to_blue = '0;
      req_elapsed_time = '0;
      req_fade_length = '0;
      req_linear_mode = 1'b0;
      req_brightness = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      tick_period = 10'(TICK_MS_RESET);
      for (int c = 0; c < 3; c++) begin
         colour_level[c] = '0;
         colour_rate[c] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_jump_and_manual();
      test_linear_extremes();
      test_fade_sequences(100, 1023, 0, 0);
      test_fade_sequences(100, 1, 78, 0);
      test_fade_sequences(100, 1000, 0, 78);
      test_fade_sequences(100, 0, 8, 8);
      test_fade_sequences(100, $urandom_range(2, 999), 78, 78);
      test_fade_sequences(100, TICK_MS_RESET, 0, 0);

      drain_engine();
      $display("Sent %0d items and checked %0d strip results over %0d tick periods,",
         items_sent, strips_checked, period_settings);
      $display("covering jumps, linear fades, manual loads, unused kinds and throttling.");
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
